@@ sv/pressure_seek_valve_control_macros.svh @@
`ifndef PRESSURE_SEEK_VALVE_CONTROL_MACROS_SVH
`define PRESSURE_SEEK_VALVE_CONTROL_MACROS_SVH

// same-cycle implication, checked outside reset
`define PSVC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PSVC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/psvc_pkg.sv @@
`default_nettype none

package psvc_pkg;

    localparam logic CMD_POLL = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    localparam int BAND_LOW     = -5;
    localparam int BAND_HIGH    = 2;
    localparam logic [7:0] OVERSHOOT    = 8'd3;
    localparam logic [7:0] RAPID_FLOOR  = 8'd15;
    localparam logic [31:0] RAPID_GAP_MS = 32'd250;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    typedef struct packed {
        logic        seeking;
        dir_t        direction;
        logic [7:0]  goal;
        logic [31:0] last_stamp;
        logic [31:0] last_pulse_ms;
        logic        pulse_valid;
    } state_t;

    typedef struct packed {
        logic        command;
        logic [7:0]  current_pressure;
        logic [7:0]  target_pressure;
        logic [31:0] pressure_stamp;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [7:0] valve_bits;
        logic       rapid;
        logic       still_going;
    } result_t;

    function automatic logic [7:0] fill_mask(input logic [1:0] ch);
        logic [7:0] m;
        case (ch)
            2'd0:    m = 8'h80;
            2'd1:    m = 8'h20;
            2'd2:    m = 8'h08;
            default: m = 8'h02;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] dump_mask(input logic [1:0] ch);
        logic [7:0] m;
        case (ch)
            2'd0:    m = 8'h40;
            2'd1:    m = 8'h10;
            2'd2:    m = 8'h04;
            default: m = 8'h01;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

@@ sv/psvc_step.sv @@
`default_nettype none

module psvc_step (
    input  psvc_pkg::state_t  st,
    input  psvc_pkg::item_t   item,
    input  logic [1:0]        chan,
    output psvc_pkg::state_t  st_next,
    output psvc_pkg::result_t res
);
    import psvc_pkg::*;

    logic signed [8:0] diff;
    logic [7:0]        over;
    logic [31:0]       gap;
    logic              in_band;
    logic              done;

    // target minus current in a signed 9-bit range
    assign diff = $signed({1'b0, item.target_pressure}) - $signed({1'b0, item.current_pressure});
    assign in_band = (diff >= 9'(BAND_LOW)) && (diff <= 9'(BAND_HIGH));
    assign over = item.current_pressure - st.goal;
    assign gap = item.now_ms - st.last_pulse_ms;

    always_comb
    begin
        st_next = st;
        res     = '0;
        done    = 1'b1;
        if (item.command == CMD_SET)
        begin
            st_next.goal = item.target_pressure;
            if (in_band)
            begin
                st_next.direction = DIR_NONE;
                st_next.seeking   = 1'b0;
            end
            else if (diff > 9'sd0)
            begin
                st_next.direction = DIR_UP;
                st_next.seeking   = 1'b1;
            end
            else
            begin
                st_next.direction     = DIR_DOWN;
                st_next.seeking       = 1'b1;
                st_next.pulse_valid   = 1'b0;
                st_next.last_pulse_ms = '0;
            end
        end
        else
        begin
            if (st.seeking && st.direction == DIR_UP)
            begin
                if (!(item.current_pressure > st.goal && over > OVERSHOOT))
                begin
                    done             = 1'b0;
                    res.still_going  = 1'b1;
                    res.valve_bits   = fill_mask(chan);
                end
            end
            else if (st.seeking && st.direction == DIR_DOWN)
            begin
                if (item.current_pressure >= st.goal)
                begin
                    done            = 1'b0;
                    res.still_going = 1'b1;
                    // at most one dump pulse per fresh sample
                    if (item.pressure_stamp != st.last_stamp)
                    begin
                        st_next.last_stamp = item.pressure_stamp;
                        if (item.current_pressure >= RAPID_FLOOR && st.goal >= RAPID_FLOOR)
                        begin
                            if (!(st.pulse_valid && gap < RAPID_GAP_MS))
                            begin
                                st_next.last_pulse_ms = item.now_ms;
                                st_next.pulse_valid   = 1'b1;
                                res.rapid             = 1'b1;
                                res.valve_bits        = dump_mask(chan);
                            end
                        end
                        else
                        begin
                            res.valve_bits = dump_mask(chan);
                        end
                    end
                end
            end
            if (done)
            begin
                st_next.seeking = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/pressure_seek_valve_control.sv @@
// channel   direction  handshake           words
// input     in         in_valid/in_stall   command, pressures, stamp, now_ms
// output    out        out_valid/out_stall valve_bits, rapid, still_going
// config    in         cfg_valid/cfg_ready cfg_data (channel index)
//
// one word per cycle sustained while out_stall is low; input register then result register
// the decision for a word is one short compare/subtract pass against the seek state
// rst_n clears the seek state, channel index and both valid flags at once
// a stalled result holds the result register; the input register keeps taking a
// word as long as it is empty or the result register is free or being drained
`default_nettype none
`include "pressure_seek_valve_control_macros.svh"

module pressure_seek_valve_control (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [7:0]  current_pressure,
    input  logic [7:0]  target_pressure,
    input  logic [31:0] pressure_stamp,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  valve_bits,
    output logic        rapid,
    output logic        still_going,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);
    import psvc_pkg::*;

    logic    s1_valid_reg;
    item_t   s1_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    state_t  st_reg;
    state_t  st_next;
    result_t res_next;
    logic [1:0] chan_reg;
    logic    out_free;
    logic    s1_fire;
    logic    in_fire;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_fire  = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    psvc_step u_step (
        .st      (st_reg),
        .item    (s1_item_reg),
        .chan    (chan_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '{seeking: 1'b0, direction: DIR_NONE, goal: '0,
                               last_stamp: '0, last_pulse_ms: '0, pulse_valid: 1'b0};
            chan_reg      <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                chan_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= '{command: command, current_pressure: current_pressure,
                             target_pressure: target_pressure,
                             pressure_stamp: pressure_stamp, now_ms: now_ms};
        end
        if (s1_fire)
        begin
            out_res_reg <= res_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign valve_bits  = out_res_reg.valve_bits;
    assign rapid       = out_res_reg.rapid;
    assign still_going = out_res_reg.still_going;

    `PSVC_ASSERT_NOW(a_one_valve, out_valid_reg, $onehot0(out_res_reg.valve_bits), "more than one valve bit driven")
    `PSVC_ASSERT_NOW(a_rapid_pulse, out_valid_reg && out_res_reg.rapid, $onehot(out_res_reg.valve_bits) && out_res_reg.still_going, "rapid flag without a dump pulse")
    `PSVC_ASSERT_NOW(a_idle_closed, out_valid_reg && !out_res_reg.still_going, out_res_reg.valve_bits == 8'h00, "valve driven with seek finished")
    `PSVC_ASSERT_NEXT(a_result_kept, out_valid_reg && out_stall, out_valid_reg && $stable(out_res_reg), "stalled result lost")
    `PSVC_ASSERT_NEXT(a_set_clears_out, s1_fire && s1_item_reg.command == CMD_SET, out_res_reg == '0, "set-target produced nonzero result")

endmodule

`default_nettype wire
